// ===== sv/swm_pkg.sv =====
package swm_pkg;

	// Default size of the pattern store, in bytes.
	localparam int unsigned PATTERN_MAX_DEF = 32;

	// Pattern byte that matches any run of text bytes.
	localparam logic [7:0] STAR_BYTE = 8'd42;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_TEXT   = 2'd2,
		OP_END    = 2'd3
	} op_t;

endpackage

// ===== sv/swm_in_if.sv =====
interface swm_in_if;
	logic            valid;
	logic            ready;
	swm_pkg::op_t    op;
	logic [7:0]      data_byte;

	modport source (output valid, output op, output data_byte, input ready);
	modport sink (input valid, input op, input data_byte, output ready);
endinterface

// ===== sv/swm_out_if.sv =====
interface swm_out_if;
	logic valid;
	logic ready;
	logic matched;
	logic overflow;

	modport source (output valid, output matched, output overflow, input ready);
	modport sink (input valid, input matched, input overflow, output ready);
endinterface

// ===== sv/swm_nfa.sv =====
// Advances the active position set by one text byte and reports whether the
// final position is reachable. Star closure is a parallel-prefix chain.
module swm_nfa #(
	parameter int unsigned PATTERN_MAX = swm_pkg::PATTERN_MAX_DEF
) (
	input  logic [PATTERN_MAX-1:0][7:0]           store,
	input  logic [PATTERN_MAX-1:0]                live,
	input  logic [PATTERN_MAX:0]                  set,
	input  logic [7:0]                            data_byte,
	input  logic [$clog2(PATTERN_MAX+1)-1:0]      len,
	output logic [PATTERN_MAX:0]                  next_set,
	output logic                                  hit
);

	localparam int unsigned LVLS = $clog2(PATTERN_MAX + 1);

	logic [PATTERN_MAX-1:0] star;
	logic [PATTERN_MAX-1:0] lit;
	logic [PATTERN_MAX:0]   gen [LVLS+1];
	logic [PATTERN_MAX:0]   prop [LVLS];
	logic [PATTERN_MAX:0]   closure;

	genvar i, l;

	generate
		for (i = 0; i < PATTERN_MAX; i++) begin : g_cmp
			assign star[i] = live[i] && (store[i] == swm_pkg::STAR_BYTE);
			assign lit[i]  = live[i] && (store[i] != swm_pkg::STAR_BYTE) &&
				(store[i] == data_byte);
		end
	endgenerate

	// Position j inherits from j-1 when pattern byte j-1 is a live star.
	assign gen[0]  = set;
	assign prop[0] = {star, 1'b0};

	generate
		for (l = 0; l < LVLS; l++) begin : g_lvl
			for (i = 0; i <= PATTERN_MAX; i++) begin : g_bit
				if (i >= (1 << l)) begin : g_comb
					assign gen[l+1][i] = gen[l][i] | (prop[l][i] & gen[l][i-(1<<l)]);
					if (l < LVLS - 1) begin : g_p
						assign prop[l+1][i] = prop[l][i] & prop[l][i-(1<<l)];
					end
				end else begin : g_pass
					assign gen[l+1][i] = gen[l][i];
					if (l < LVLS - 1) begin : g_p
						assign prop[l+1][i] = prop[l][i];
					end
				end
			end
		end
	endgenerate

	assign closure = gen[LVLS];
	assign hit     = closure[len];

	generate
		for (i = 0; i <= PATTERN_MAX; i++) begin : g_next
			if (i == 0) begin : g_first
				assign next_set[i] = closure[i] & star[i];
			end else if (i == PATTERN_MAX) begin : g_last
				assign next_set[i] = closure[i-1] & lit[i-1];
			end else begin : g_mid
				assign next_set[i] = (closure[i] & star[i]) | (closure[i-1] & lit[i-1]);
			end
		end
	endgenerate

endmodule

// ===== sv/star_wildcard_matcher.sv =====
// Star-only wildcard matcher.
// Words arrive on text_in, each carrying an op and a data byte. Clear empties
// the pattern and the overflow flag; append adds one pattern byte ('*' is the
// wildcard that matches any run, including an empty one); text feeds one text
// byte; end of text produces one word on result with matched and overflow,
// then rearms the matcher for the next text while keeping the pattern.
// Only end-of-text words produce a result word; all other ops produce none.
// An append also rearms the matcher, so a text in progress restarts.
// A pattern longer than PATTERN_MAX bytes sets a sticky overflow flag, which
// forces matched low until the next clear.
// Throughput is one word per cycle for every op unless an end-of-text word
// waits on a stalled result register; the whole active position set is
// updated in the single compare-and-closure stage behind the input register.
// When the receiver stalls, the result register holds its word and text_in
// keeps accepting words until an end-of-text word waits behind it.
// Reset leaves an empty pattern, the overflow flag low, only position zero
// active and both channels empty.
module star_wildcard_matcher #(
	parameter int unsigned PATTERN_MAX = swm_pkg::PATTERN_MAX_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	swm_in_if.sink         text_in,
	swm_out_if.source      result
);

	localparam int unsigned LW = $clog2(PATTERN_MAX + 1);

	// Input stage.
	logic                 valid_s1;
	swm_pkg::op_t         op_s1;
	logic [7:0]           byte_s1;

	// Matcher state.
	logic [PATTERN_MAX-1:0][7:0] store_q;
	logic [LW-1:0]               len_q;
	logic                        ovf_q;
	logic [PATTERN_MAX:0]        set_q;

	// Result register.
	logic                 out_valid_q;
	logic                 matched_q;
	logic                 overflow_q;

	logic                   go_s1;
	logic                   fire_s1;
	logic                   full;
	logic [PATTERN_MAX-1:0] live;
	logic [PATTERN_MAX:0]   next_set;
	logic                   hit;

	localparam logic [PATTERN_MAX:0] SET_REARM = {{PATTERN_MAX{1'b0}}, 1'b1};

	// Only an end-of-text word needs room in the result register.
	assign go_s1   = (op_s1 != swm_pkg::OP_END) || !out_valid_q || result.ready;
	assign fire_s1 = valid_s1 && go_s1;
	assign text_in.ready = !valid_s1 || go_s1;

	assign full = (len_q == LW'(PATTERN_MAX));

	genvar i;
	generate
		for (i = 0; i < PATTERN_MAX; i++) begin : g_live
			assign live[i] = (len_q > LW'(i));
		end
	endgenerate

	swm_nfa #(
		.PATTERN_MAX (PATTERN_MAX)
	) u_nfa (
		.store     (store_q),
		.live      (live),
		.set       (set_q),
		.data_byte (byte_s1),
		.len       (len_q),
		.next_set  (next_set),
		.hit       (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_in.valid && text_in.ready) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text_in.valid && text_in.ready) begin
			op_s1   <= text_in.op;
			byte_s1 <= text_in.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			ovf_q <= 1'b0;
			set_q <= SET_REARM;
		end else if (fire_s1) begin
			case (op_s1)
				swm_pkg::OP_CLEAR: begin
					len_q <= '0;
					ovf_q <= 1'b0;
					set_q <= SET_REARM;
				end
				swm_pkg::OP_APPEND: begin
					if (full) begin
						ovf_q <= 1'b1;
					end else begin
						len_q <= len_q + LW'(1);
					end
					set_q <= SET_REARM;
				end
				swm_pkg::OP_TEXT: begin
					set_q <= next_set;
				end
				default: begin
					set_q <= SET_REARM;
				end
			endcase
		end
	end

	// The entry at the current length takes the appended byte.
	always_ff @(posedge clk) begin
		for (int k = 0; k < PATTERN_MAX; k++) begin
			if (fire_s1 && (op_s1 == swm_pkg::OP_APPEND) && (len_q == LW'(k))) begin
				store_q[k] <= byte_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && (op_s1 == swm_pkg::OP_END)) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && (op_s1 == swm_pkg::OP_END)) begin
			matched_q  <= hit && !ovf_q;
			overflow_q <= ovf_q;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.matched  = matched_q;
	assign result.overflow = overflow_q;

	// The overflow flag is only ever raised with a full store.
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> full)
		else $error("overflow flag set while store not full");

	// The length never passes the store size.
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(PATTERN_MAX))
		else $error("pattern length beyond store");

	// No active position lies past the end of the pattern.
	a_set_bound: assert property (@(posedge clk) disable iff (!arst_n)
		((set_q >> len_q) >> 1) == '0)
		else $error("active position past pattern end");

	// A new result word comes only from an end-of-text word in the input stage.
	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !$past(out_valid_q && !result.ready)) |->
		$past(valid_s1 && (op_s1 == swm_pkg::OP_END)))
		else $error("result word without end of text");

	// A match is never reported together with overflow.
	a_match_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && matched_q) |-> !overflow_q)
		else $error("match reported with overflow");

endmodule

// ===== bench/tb_top.sv =====
module tb_top;

	// Size of the pattern store in the block under test. The run also pushes
	// patterns a few bytes past it, to reach the sticky overflow flag.
	localparam int PMAX = swm_pkg::PATTERN_MAX_DEF;

	localparam int HALF_PERIOD  = 6;
	localparam int RESET_CYCLES = 8;
	// Number of input words that the stimulus aims for.
	localparam int N_WORDS      = 1300;
	// A result word follows its end-of-text word through the input and result
	// registers, so this drain after the last expected verdict catches a stray word.
	localparam int DRAIN_CYCLES = 8;
	// Cycles in a row with no word moving on either channel before giving up.
	localparam int QUIET_LIMIT  = 2000;

	localparam logic [7:0] CHAR_A = 8'h61;
	localparam logic [7:0] CHAR_B = 8'h62;

	// Active set with only position zero, as after reset or a rearm.
	localparam logic [PMAX:0] SET_REARM = {{PMAX{1'b0}}, 1'b1};

	typedef struct packed {
		swm_pkg::op_t op;
		logic [7:0]   data;
	} in_word_t;

	typedef struct packed {
		logic matched;
		logic overflow;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	swm_in_if  text_ch ();
	swm_out_if res_ch ();

	star_wildcard_matcher dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text_in(text_ch),
		.result (res_ch)
	);

	always #HALF_PERIOD clk = ~clk;

	// Words waiting to be driven, filled once at time zero.
	in_word_t word_q[$];
	int       n_queued = 0;
	int       words_taken = 0;
	in_word_t next_word;

	// Verdicts that the block still owes, oldest first.
	verdict_t verdict_q[$];
	verdict_t got_verdict;
	verdict_t want_verdict;

	int n_errors = 0;
	int quiet_cycles = 0;

	// Shadow state of the matcher. live_set bit i set means that the first
	// i pattern bytes can have consumed the text seen so far, with the empty
	// matches of stars not yet applied.
	logic [7:0]  pat_mem [PMAX];
	int unsigned pat_len = 0;
	logic [PMAX:0] live_set = SET_REARM;
	logic        pat_ovf = 1'b0;

	// Let every active star also match the empty run, so the position right
	// after it becomes active too. Walking upward carries this through a chain
	// of stars in one pass.
	function automatic logic [PMAX:0] star_extend(logic [PMAX:0] s);
		for (int i = 0; i < pat_len; i++) begin
			if (s[i] && pat_mem[i] == swm_pkg::STAR_BYTE)
				s[i+1] = 1'b1;
		end
		return s;
	endfunction

	// Apply one accepted word to the shadow state. An end-of-text word yields
	// the verdict that the block must return.
	task automatic apply_word(swm_pkg::op_t op, logic [7:0] b);
		logic [PMAX:0] s;
		logic [PMAX:0] nxt;
		verdict_t v;
		case (op)
			swm_pkg::OP_CLEAR: begin
				pat_len  = 0;
				pat_ovf  = 1'b0;
				live_set = SET_REARM;
			end
			swm_pkg::OP_APPEND: begin
				if (pat_len < PMAX) begin
					pat_mem[pat_len] = b;
					pat_len++;
				end else begin
					pat_ovf = 1'b1;
				end
				// Any append restarts a text that is in progress.
				live_set = SET_REARM;
			end
			swm_pkg::OP_TEXT: begin
				s   = star_extend(live_set);
				nxt = '0;
				for (int i = 0; i < pat_len; i++) begin
					if (s[i]) begin
						// A star swallows the byte and stays put; a literal
						// byte moves on only if it matches.
						if (pat_mem[i] == swm_pkg::STAR_BYTE)
							nxt[i] = 1'b1;
						else if (pat_mem[i] == b)
							nxt[i+1] = 1'b1;
					end
				end
				live_set = nxt;
			end
			swm_pkg::OP_END: begin
				s          = star_extend(live_set);
				v.matched  = s[pat_len] && !pat_ovf;
				v.overflow = pat_ovf;
				verdict_q.push_back(v);
				live_set   = SET_REARM;
			end
		endcase
	endtask

	task automatic report_mismatch(string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		n_errors++;
	endtask

	task automatic queue_word(swm_pkg::op_t op, logic [7:0] b);
		in_word_t w;
		w.op   = op;
		w.data = b;
		word_q.push_back(w);
		n_queued++;
	endtask

	// Pattern bytes lean on a two-letter alphabet and stars, so that random
	// texts match often enough; now and then any byte at all.
	function automatic logic [7:0] pattern_letter();
		int r;
		r = $urandom_range(9);
		if (r < 4)
			return CHAR_A;
		else if (r < 6)
			return CHAR_B;
		else if (r < 9)
			return swm_pkg::STAR_BYTE;
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [7:0] text_letter();
		int r;
		r = $urandom_range(9);
		if (r < 5)
			return CHAR_A;
		else if (r < 9)
			return CHAR_B;
		return 8'($urandom_range(255));
	endfunction

	// Idling follows the progress of the run: first the sender idles a
	// quarter of the time and the receiver stalls about half, then the other
	// way round, and in the last third neither side holds back.
	function automatic int send_idle_pct();
		if (words_taken < n_queued / 3)
			return 25;
		else if (words_taken < 2 * n_queued / 3)
			return 52;
		return 0;
	endfunction

	function automatic int recv_stall_pct();
		if (words_taken < n_queued / 3)
			return 52;
		else if (words_taken < 2 * n_queued / 3)
			return 25;
		return 0;
	endfunction

	// Driver. When the word on the bus is taken, or the bus is empty, it
	// either offers the next pending word or leaves a gap. Valid and the
	// payload are assigned once per edge, so a word that follows another
	// directly keeps valid high without a glitch.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_ch.valid     <= 1'b0;
			text_ch.op        <= swm_pkg::OP_CLEAR;
			text_ch.data_byte <= '0;
		end else begin
			if (text_ch.valid && text_ch.ready) begin
				apply_word(text_ch.op, text_ch.data_byte);
				words_taken <= words_taken + 1;
			end
			if (!text_ch.valid || text_ch.ready) begin
				if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
					next_word = word_q.pop_front();
					text_ch.valid     <= 1'b1;
					text_ch.op        <= next_word.op;
					text_ch.data_byte <= next_word.data;
				end else begin
					text_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor. Every result word taken is checked against the oldest
	// verdict still owed, field by field.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				got_verdict.matched  = res_ch.matched;
				got_verdict.overflow = res_ch.overflow;
				if (verdict_q.size() == 0) begin
					report_mismatch($sformatf("result word matched=%0b overflow=%0b %s",
						got_verdict.matched, got_verdict.overflow,
						"with no end-of-text word pending"));
				end else begin
					want_verdict = verdict_q.pop_front();
					if (got_verdict.matched !== want_verdict.matched)
						report_mismatch($sformatf("matched is %0b, expected %0b",
							got_verdict.matched, want_verdict.matched));
					if (got_verdict.overflow !== want_verdict.overflow)
						report_mismatch($sformatf("overflow is %0b, expected %0b",
							got_verdict.overflow, want_verdict.overflow));
				end
			end
			res_ch.ready <= ($urandom_range(99) >= recv_stall_pct());
		end
	end

	// Watchdog. A run that stops moving words on both channels is hung.
	always @(posedge clk) begin
		if (!arst_n || (text_ch.valid && text_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("star_wildcard_matcher test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [7:0] pat[$];
		logic [7:0] txt[$];
		int plen;
		int n_texts;
		int run;
		int k;
		int cut;
		int seq;

		text_ch.valid     = 1'b0;
		text_ch.op        = swm_pkg::OP_CLEAR;
		text_ch.data_byte = '0;
		res_ch.ready      = 1'b0;

		// Directed words. Right after reset the pattern is empty, and an
		// empty pattern matches only the empty text.
		queue_word(swm_pkg::OP_END, 8'hFF);
		queue_word(swm_pkg::OP_TEXT, 8'h00);
		queue_word(swm_pkg::OP_END, 8'h00);
		// Pattern with both extreme byte values around a star.
		queue_word(swm_pkg::OP_CLEAR, 8'hFF);
		queue_word(swm_pkg::OP_APPEND, 8'h00);
		queue_word(swm_pkg::OP_APPEND, swm_pkg::STAR_BYTE);
		queue_word(swm_pkg::OP_APPEND, 8'hFF);
		// The star takes the empty run.
		queue_word(swm_pkg::OP_TEXT, 8'h00);
		queue_word(swm_pkg::OP_TEXT, 8'hFF);
		queue_word(swm_pkg::OP_END, 8'h55);
		// The star takes a run of two bytes.
		queue_word(swm_pkg::OP_TEXT, 8'h00);
		queue_word(swm_pkg::OP_TEXT, 8'h5A);
		queue_word(swm_pkg::OP_TEXT, 8'hA5);
		queue_word(swm_pkg::OP_TEXT, 8'hFF);
		queue_word(swm_pkg::OP_END, 8'hAA);
		// A text that stops short of the last pattern byte fails.
		queue_word(swm_pkg::OP_TEXT, 8'h00);
		queue_word(swm_pkg::OP_END, 8'h00);
		// An append in the middle of a text restarts it.
		queue_word(swm_pkg::OP_TEXT, 8'h00);
		queue_word(swm_pkg::OP_APPEND, swm_pkg::STAR_BYTE);
		queue_word(swm_pkg::OP_TEXT, 8'h00);
		queue_word(swm_pkg::OP_TEXT, 8'hFF);
		queue_word(swm_pkg::OP_END, 8'hFF);
		// A lone star matches the empty text.
		queue_word(swm_pkg::OP_CLEAR, 8'h00);
		queue_word(swm_pkg::OP_APPEND, swm_pkg::STAR_BYTE);
		queue_word(swm_pkg::OP_END, 8'h00);

		// Random part. Most of it is a clear, a pattern and a few texts that
		// are built from the pattern and then sometimes damaged, so that both
		// verdicts come up often. Short bursts of arbitrary words are mixed
		// in. The second sequence always runs past the store to raise the
		// overflow flag; later ones do so now and then.
		seq = 0;
		while (n_queued < N_WORDS) begin
			if (seq != 1 && $urandom_range(99) < 8) begin
				repeat ($urandom_range(1, 6))
					queue_word(swm_pkg::op_t'($urandom_range(3)), 8'($urandom_range(255)));
			end else begin
				if (seq == 1 || $urandom_range(9) != 0)
					queue_word(swm_pkg::OP_CLEAR, 8'($urandom_range(255)));
				if (seq == 1)
					plen = PMAX + 2;
				else if ($urandom_range(11) == 0)
					plen = $urandom_range(PMAX + 4, PMAX - 2);
				else
					plen = $urandom_range(7);
				pat = {};
				repeat (plen) begin
					pat.push_back(pattern_letter());
					queue_word(swm_pkg::OP_APPEND, pat[$]);
				end
				n_texts = $urandom_range(1, 4);
				repeat (n_texts) begin
					txt = {};
					if ($urandom_range(99) < 15) begin
						repeat ($urandom_range(6))
							txt.push_back(text_letter());
					end else begin
						foreach (pat[j]) begin
							if (pat[j] == swm_pkg::STAR_BYTE) begin
								run = $urandom_range(3);
								repeat (run)
									txt.push_back(text_letter());
							end else begin
								txt.push_back(pat[j]);
							end
						end
						// Damage the text by dropping a byte or swapping a letter.
						if (txt.size() != 0 && $urandom_range(99) < 35) begin
							k = $urandom_range(txt.size() - 1);
							if ($urandom_range(1))
								txt.delete(k);
							else
								txt[k] = txt[k] ^ 8'h03;
						end
					end
					cut = ($urandom_range(99) < 5) ? $urandom_range(txt.size()) : -1;
					foreach (txt[j]) begin
						if (j == cut) begin
							pat.push_back(pattern_letter());
							queue_word(swm_pkg::OP_APPEND, pat[$]);
						end
						queue_word(swm_pkg::OP_TEXT, txt[j]);
					end
					queue_word(swm_pkg::OP_END, 8'($urandom_range(255)));
				end
			end
			seq++;
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		while (words_taken != n_queued)
			@(posedge clk);
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (n_errors == 0)
			$display("star_wildcard_matcher test passed");
		else
			$display("star_wildcard_matcher test failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/swm_pkg.sv
sv/swm_in_if.sv
sv/swm_out_if.sv
sv/swm_nfa.sv
sv/star_wildcard_matcher.sv
bench/tb_top.sv
